@@ rtl/eav_pkg.sv @@
// shared types, character codes and status codes for the address validator
package eav_pkg;

	localparam int unsigned MAX_COMMENT_DEPTH = 255;
	localparam int unsigned DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);

	localparam logic [1:0] CTX_TOP = 2'd0;
	localparam logic [1:0] CTX_COMMENT = 2'd1;
	localparam logic [1:0] CTX_ANGLE = 2'd2;

	localparam logic [7:0] CH_AT = 8'h40;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LANGLE = 8'h3C;
	localparam logic [7:0] CH_RANGLE = 8'h3E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_EMPTY = 4'd1;
	localparam logic [3:0] ST_TOO_FEW_AT = 4'd2;
	localparam logic [3:0] ST_TOO_MANY_AT = 4'd3;
	localparam logic [3:0] ST_NO_LOCAL = 4'd4;
	localparam logic [3:0] ST_NO_DOMAIN = 4'd5;
	localparam logic [3:0] ST_PARENS = 4'd6;
	localparam logic [3:0] ST_QUOTE = 4'd7;
	localparam logic [3:0] ST_UNCLOSED_ANGLE = 4'd8;
	localparam logic [3:0] ST_UNOPENED_ANGLE = 4'd9;
	localparam logic [3:0] ST_COMMA = 4'd10;
	localparam logic [3:0] ST_END = 4'd11;
	localparam logic [3:0] ST_DISALLOWED = 4'd12;
	localparam logic [3:0] ST_BAD_NAME = 4'd13;

	localparam logic [1:0] AT_SAT = 2'd2;

	typedef struct packed {
		logic [1:0]         context_mode;
		logic               in_quotes;
		logic [DEPTH_W-1:0] comment_depth;
		logic               skip_next;
		logic               seen_first;
		logic [3:0]         error_latched;
		logic               any_at_seen;
		logic [1:0]         unquoted_at_count;
	} eav_state_t;

	localparam eav_state_t STATE_RST = '0;

endpackage

@@ rtl/email_address_validator_core.sv @@
// top level: input register, scanner state, status result register
// One character item is taken per cycle unless the input stalls; each item is held in the input register, where
// the scanner state is updated, and the status for an address appears in the result register
// the cycle after its last byte (or the empty-address marker) leaves the input register.
// The result register lets the next address be accepted while a status still waits; the input
// stalls only when a finished status is held back and another status is about to be produced.
module email_address_validator_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  logic [7:0] char_byte,
	input  logic       last_byte,
	input  logic       empty_string,
	output logic       status_valid,
	input  logic       status_stall,
	output logic [3:0] status_code
);
	import eav_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       empty_s1;

	eav_state_t state_q;
	eav_state_t state_nxt;
	logic [3:0] code_nxt;
	logic       status_valid_q;
	logic [3:0] status_code_q;

	logic       out_free;
	logic       ends_s1;
	logic       fire_s1;
	logic       accept;

	assign out_free = !status_valid_q || !status_stall;
	assign ends_s1 = last_s1 || empty_s1;
	assign fire_s1 = valid_s1 && (!ends_s1 || out_free);
	assign char_stall = valid_s1 && !fire_s1;
	assign accept = char_valid && !char_stall;

	eav_scan u_scan (
		.cur          (state_q),
		.char_byte    (char_s1),
		.last_byte    (last_s1),
		.empty_string (empty_s1),
		.nxt          (state_nxt),
		.status_code  (code_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_byte;
			last_s1 <= last_byte;
			empty_s1 <= empty_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid_q <= 1'b0;
		end else if (out_free) begin
			status_valid_q <= fire_s1 && ends_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && ends_s1) begin
			status_code_q <= code_nxt;
		end
	end

	assign status_valid = status_valid_q;
	assign status_code = status_code_q;

	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(status_valid_q) |-> $past(fire_s1 && ends_s1))
		else $error("status appeared without an ending item");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && ends_s1) |=> (state_q == STATE_RST))
		else $error("scanner state not cleared after address end");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.error_latched != ST_OK && fire_s1 && !ends_s1)
		|=> (state_q.error_latched == $past(state_q.error_latched)))
		else $error("latched error changed mid-address");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid_q |-> (status_code_q <= ST_BAD_NAME))
		else $error("status code out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(status_valid_q && status_stall) |=> (status_valid_q && $stable(status_code_q)))
		else $error("held status overwritten");

endmodule

@@ rtl/eav_scan.sv @@
// per-item scan step: next scanner state and the end-of-address status
module eav_scan (
	input  eav_pkg::eav_state_t cur,
	input  logic [7:0]          char_byte,
	input  logic                last_byte,
	input  logic                empty_string,
	output eav_pkg::eav_state_t nxt,
	output logic [3:0]          status_code
);
	import eav_pkg::*;

	eav_state_t         upd;
	logic [3:0]         lat;
	logic               at_inc;
	logic [DEPTH_W-1:0] dec_depth;

	always_comb begin
		upd = cur;
		lat = ST_OK;
		at_inc = 1'b0;
		dec_depth = (cur.comment_depth != '0) ? cur.comment_depth - 1'b1 : '0;

		if (char_byte == CH_AT) begin
			upd.any_at_seen = 1'b1;
		end

		if (cur.error_latched == ST_OK) begin
			if (cur.skip_next) begin
				upd.skip_next = 1'b0;
				at_inc = (char_byte == CH_AT);
			end else if (cur.context_mode == CTX_COMMENT) begin
				case (char_byte)
					CH_LPAREN: begin
						if (cur.comment_depth < DEPTH_W'(MAX_COMMENT_DEPTH)) begin
							upd.comment_depth = cur.comment_depth + 1'b1;
						end
					end
					CH_RPAREN: begin
						upd.comment_depth = dec_depth;
						if (dec_depth == '0) begin
							upd.context_mode = CTX_TOP;
						end
					end
					CH_BSLASH: begin
						upd.skip_next = 1'b1;
						if (last_byte) lat = ST_END;
					end
					CH_AT: at_inc = 1'b1;
					default: ;
				endcase
			end else if (cur.context_mode == CTX_ANGLE) begin
				case (char_byte)
					CH_COMMA: if (!cur.in_quotes) lat = ST_COMMA;
					CH_DQUOTE: upd.in_quotes = !cur.in_quotes;
					CH_AT: at_inc = !cur.in_quotes;
					CH_RANGLE: if (!cur.in_quotes) upd.context_mode = CTX_TOP;
					CH_BSLASH: begin
						upd.skip_next = 1'b1;
						if (last_byte) lat = ST_END;
					end
					default: ;
				endcase
			end else begin
				case (char_byte)
					CH_DQUOTE: upd.in_quotes = !cur.in_quotes;
					CH_LPAREN: begin
						if (!cur.in_quotes) begin
							upd.context_mode = CTX_COMMENT;
							upd.comment_depth = DEPTH_W'(1);
						end
					end
					CH_LBRACK, CH_RBRACK: if (!cur.in_quotes) lat = ST_BAD_NAME;
					CH_COLON: if (!cur.in_quotes) lat = ST_DISALLOWED;
					CH_LANGLE: if (!cur.in_quotes) upd.context_mode = CTX_ANGLE;
					CH_BSLASH: begin
						upd.skip_next = 1'b1;
						if (last_byte) lat = ST_END;
					end
					CH_COMMA: if (!cur.in_quotes) lat = ST_COMMA;
					CH_RPAREN: if (!cur.in_quotes) lat = ST_PARENS;
					CH_RANGLE: if (!cur.in_quotes) lat = ST_UNOPENED_ANGLE;
					CH_AT: begin
						if (!cur.in_quotes) begin
							at_inc = 1'b1;
							// leading @ wins over trailing @
							if (!cur.seen_first) lat = ST_NO_LOCAL;
							else if (last_byte) lat = ST_NO_DOMAIN;
						end
					end
					default: ;
				endcase
			end
			upd.error_latched = lat;
		end

		if (at_inc && cur.unquoted_at_count != AT_SAT) begin
			upd.unquoted_at_count = cur.unquoted_at_count + 1'b1;
		end
		upd.seen_first = 1'b1;

		// end checks in priority order; an empty address overrides them all below
		if (!upd.any_at_seen) status_code = ST_TOO_FEW_AT;
		else if (upd.error_latched != ST_OK) status_code = upd.error_latched;
		else if (upd.unquoted_at_count == '0 && !upd.in_quotes) status_code = ST_TOO_FEW_AT;
		else if (upd.in_quotes) status_code = ST_QUOTE;
		else if (upd.context_mode == CTX_COMMENT) status_code = ST_PARENS;
		else if (upd.context_mode == CTX_ANGLE) status_code = ST_UNCLOSED_ANGLE;
		else if (upd.unquoted_at_count == AT_SAT) status_code = ST_TOO_MANY_AT;
		else status_code = ST_OK;

		if (empty_string) begin
			status_code = ST_EMPTY;
			nxt = STATE_RST;
		end else if (last_byte) begin
			nxt = STATE_RST;
		end else begin
			nxt = upd;
		end
	end

endmodule
